@@ sv/d2i_pkg.sv @@
// Package with shared types and constants for the double to integer converter.
`default_nettype none
package d2i_pkg;
    localparam int unsigned DoubleWidth = 64;
    localparam int unsigned IntWidth    = 32;
    localparam int unsigned FracWidth   = 52;
    localparam int unsigned ExpWidth    = 11;
    localparam int unsigned InDataWidth  = 72;
    localparam int unsigned OutDataWidth = 32;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_RSVD = 2'd3
    } width_code_t;

    localparam logic [1:0] REG_WIDTH_CODE = 2'd0;
    localparam logic [1:0] REG_IS_SIGNED  = 2'd1;

    localparam logic [ExpWidth-1:0] EXP_SPECIAL = 11'h7FF;
    // Biased exponent 1055 means a magnitude of 2^32 or more.
    localparam logic [ExpWidth-1:0] EXP_SAT     = 11'd1055;
    // Below biased exponent 1022 the magnitude is under one half.
    localparam logic [ExpWidth-1:0] EXP_HALF    = 11'd1022;
endpackage
`default_nettype wire

@@ sv/double_to_int_round_saturate.sv @@
// Top level of the binary64 to integer converter with rounding and saturation.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata: double_bits, tuser: last_in
//   m_axis    out  m_axis_tvalid/tready    tdata: int_bits, tuser: last_out
//   cfg       in   cfg_we                  cfg_index, cfg_data
//
// One word per cycle while m_axis is not stalled; each word passes the input register, then the result register.
// The input stage advances whenever the result register is empty or drained.
// A stall on m_axis holds both stages; s_axis_tready drops only then.
// Reset clears the valid flags and sets the destination to signed 32 bits.
`default_nettype none
module double_to_int_round_saturate
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [63:0] double_bits
    input  wire logic        s_axis_tuser,  // [0] last_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] int_bits
    output logic             m_axis_tuser,  // [0] last_out
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [1:0]  cfg_data
);
    logic [1:0]  width_reg;
    logic        signed_reg;
    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;
    logic [31:0] result_next;
    logic        adv_out;
    logic        adv_in;

    // Field decode and rounding.
    logic                           sign_bit;
    logic [d2i_pkg::ExpWidth-1:0]   expo;
    logic [d2i_pkg::FracWidth-1:0]  frac;
    logic [63:0]                    sig_sh;
    logic [5:0]                     sh;
    logic [32:0]                    q;
    logic [32:0]                    q_rnd;
    logic                           half_bit;
    logic                           sticky;
    logic                           is_nan;
    logic                           neg;
    logic                           mag_sat;
    logic [32:0]                    mag;
    logic [32:0]                    pos_max;
    logic [32:0]                    neg_max;
    logic [32:0]                    umax;

    assign adv_out = !out_valid_reg || m_axis_tready;
    assign adv_in  = adv_out;
    assign s_axis_tready = adv_in;

    always_comb
    begin
        sign_bit = in_data_reg[63];
        expo     = in_data_reg[62:52];
        frac     = in_data_reg[51:0];
        is_nan   = (expo == d2i_pkg::EXP_SPECIAL) && (frac != '0);
        neg      = sign_bit && !is_nan;
        // Shift by 1075-expo, valid in 21..53 when expo is 1022..1054.
        sh       = 6'((12'd1075 - {1'b0, expo}) & 12'h03F);
        // Keep one guard bit below the integer part: shift by sh-1.
        sig_sh   = {11'd0, 1'b1, frac} >> (sh - 6'd1);
        q        = 33'(sig_sh >> 1);
        half_bit = sig_sh[0];
        sticky   = (({11'd0, 1'b1, frac} & ((64'd1 << (sh - 6'd1)) - 64'd1)) != '0);
        q_rnd    = (half_bit && (sticky || q[0])) ? q + 33'd1 : q;
        mag_sat  = 1'b0;
        if (expo == d2i_pkg::EXP_SPECIAL)
        begin
            mag     = '0;
            mag_sat = !is_nan;
        end
        else if (expo >= d2i_pkg::EXP_SAT)
        begin
            mag     = '0;
            mag_sat = 1'b1;
        end
        else if (expo < d2i_pkg::EXP_HALF)
        begin
            mag = '0;
        end
        else
        begin
            mag = q_rnd;
        end
        case (d2i_pkg::width_code_t'(width_reg))
            d2i_pkg::WIDTH_8:
            begin
                pos_max = 33'h7F;
                neg_max = 33'h80;
                umax    = 33'hFF;
            end
            d2i_pkg::WIDTH_16:
            begin
                pos_max = 33'h7FFF;
                neg_max = 33'h8000;
                umax    = 33'hFFFF;
            end
            default:
            begin
                pos_max = 33'h7FFF_FFFF;
                neg_max = 33'h8000_0000;
                umax    = 33'hFFFF_FFFF;
            end
        endcase
        if (signed_reg)
        begin
            if (neg)
                result_next = 32'(33'd0 - ((mag_sat || mag > neg_max) ? neg_max : mag));
            else
                result_next = 32'((mag_sat || mag > pos_max) ? pos_max : mag);
        end
        else
        begin
            if (neg)
                result_next = '0;
            else
                result_next = 32'((mag_sat || mag > umax) ? umax : mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= d2i_pkg::WIDTH_32;
            signed_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == d2i_pkg::REG_WIDTH_CODE[0:0])
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == d2i_pkg::REG_IS_SIGNED[0:0])
                signed_reg <= cfg_data[0];
            if (adv_in)
                in_valid_reg <= s_axis_tvalid;
            if (adv_out)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tuser;
        end
        if (adv_out && in_valid_reg)
        begin
            out_data_reg <= result_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_last_reg;

    // A stalled result holds its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // No input is accepted while the output is blocked.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output blocked");
    // An accepted word passes the input and result registers to the output when not stalled.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 s_axis_tready |=> m_axis_tvalid)
        else $error("word lost in pipeline");
endmodule
`default_nettype wire
